@@ rtl/core/spq_pkg.sv @@
// Shared types, codes and helpers for the stable priority queue.
package spq_pkg;

  localparam int LEVEL_W       = 3;
  localparam int NUM_LEVELS    = 8;
  localparam int TAG_W         = 16;
  localparam int CAT_W         = 2;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVE_ONE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SERVE_ALL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [LEVEL_W-1:0] level;
  } lvl_req_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic               last_one;
    logic [LEVEL_W-1:0] top_level;
  } lvl_stat_t;

  // Highest set bit of the nonempty mask.
  function automatic logic [LEVEL_W-1:0] find_top(input logic [NUM_LEVELS-1:0] mask);
    logic [LEVEL_W-1:0] top;
    top = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (mask[i]) top = LEVEL_W'(i);
    end
    return top;
  endfunction

endpackage

@@ rtl/core/spq_mem.sv @@
// Entry memory: one write port, one read port, registered read data.
module spq_mem #(
  parameter int AW = 7,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/spq_lvl.sv @@
// Per-level ring pointers and counts, and selection of the highest nonempty level.
module spq_lvl #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  spq_pkg::lvl_req_t                  req,
  output spq_pkg::lvl_stat_t                 stat,
  output logic [spq_pkg::LEVEL_W+PW-1:0]     push_addr,
  output logic [spq_pkg::LEVEL_W+PW-1:0]     pop_addr
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [PW-1:0] head [spq_pkg::NUM_LEVELS];
  logic [PW-1:0] tail [spq_pkg::NUM_LEVELS];
  logic [CW-1:0] cnt  [spq_pkg::NUM_LEVELS];
  logic [CW-1:0] total;

  logic [spq_pkg::NUM_LEVELS-1:0] nonempty;
  logic [spq_pkg::LEVEL_W-1:0]    top;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
      nonempty[i] = (cnt[i] != '0);
    end
  end

  assign top = spq_pkg::find_top(nonempty);

  assign stat.empty     = (total == '0);
  assign stat.full      = (total == CW'(DEPTH));
  assign stat.last_one  = (total == CW'(1));
  assign stat.top_level = top;

  assign push_addr = {req.level, tail[req.level]};
  assign pop_addr  = {top, head[top]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        cnt[i]  <= '0;
      end
      total <= '0;
    end else if (req.push) begin
      tail[req.level] <= wrap_inc(tail[req.level]);
      cnt[req.level]  <= cnt[req.level] + CW'(1);
      total           <= total + CW'(1);
    end else if (req.pop) begin
      head[top] <= wrap_inc(head[top]);
      cnt[top]  <= cnt[top] - CW'(1);
      total     <= total - CW'(1);
    end
  end

endmodule

@@ rtl/core/stable_priority_queue.sv @@
// Stable priority queue top level: command sequencer and output register.
//
// Input channel (in_valid / in_stall) carries one command word: cmd, level,
// customer_tag, category. Output channel (out_valid / out_stall) carries one
// result word: status, served_tag, served_level, served_category, last.
// Each priority level keeps its own ring in one shared entry memory, so
// entries of equal level leave in arrival order and the highest level
// goes first.
// Insert and serve-one: the command is accepted in the idle state, its
// result enters the output register from the emit state once that register
// is free, and the next command is accepted only after the return to idle.
// Serve-all emits one result per cycle while the receiver does not stall,
// one entry memory read each; last marks the final word. Unused command
// codes are taken and give no result. The entry memory read of a serve is
// issued at the same edge that accepts the command.
// Reset clears the level counts and pointers and empties the output
// register; memory contents are not cleared and need no sweep.
// While out_stall is high on a valid word, that word holds; the sequencer
// keeps its next result and holds in_stall high until it can hand it over.
module stable_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spq_pkg::CMD_W-1:0]     cmd,
  input  logic [spq_pkg::LEVEL_W-1:0]   level,
  input  logic [spq_pkg::TAG_W-1:0]     customer_tag,
  input  logic [spq_pkg::CAT_W-1:0]     category,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spq_pkg::STATUS_W-1:0]  status,
  output logic [spq_pkg::TAG_W-1:0]     served_tag,
  output logic [spq_pkg::LEVEL_W-1:0]   served_level,
  output logic [spq_pkg::CAT_W-1:0]     served_category,
  output logic                          last
);

  localparam int PW = $clog2(DEPTH);
  localparam int AW = spq_pkg::LEVEL_W + PW;
  localparam int DW = spq_pkg::TAG_W + spq_pkg::CAT_W;

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t                        state;
  logic                          drain;
  logic [spq_pkg::STATUS_W-1:0]  res_status;
  logic [spq_pkg::LEVEL_W-1:0]   res_level;
  logic                          res_has;
  logic                          res_last;

  spq_pkg::lvl_req_t  req;
  spq_pkg::lvl_stat_t stat;
  logic [AW-1:0]      push_addr;
  logic [AW-1:0]      pop_addr;
  logic [DW-1:0]      rdata;

  logic accept;
  logic is_serve;
  logic out_free;
  logic drain_more;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign is_serve   = (cmd == spq_pkg::CMD_SERVE_ONE) || (cmd == spq_pkg::CMD_SERVE_ALL);
  assign out_free   = !out_valid || !out_stall;
  assign drain_more = (state == S_EMIT) && out_free && drain && !res_last;

  // Push and pop are never asked for in the same cycle.
  always_comb begin
    req.level = level;
    req.push  = accept && (cmd == spq_pkg::CMD_INSERT) && !stat.full;
    req.pop   = (accept && is_serve && !stat.empty) || drain_more;
  end

  spq_lvl #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_lvl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .stat      (stat),
    .push_addr (push_addr),
    .pop_addr  (pop_addr)
  );

  spq_mem #(
    .AW (AW),
    .DW (DW)
  ) u_mem (
    .clk   (clk),
    .we    (req.push),
    .waddr (push_addr),
    .wdata ({customer_tag, category}),
    .re    (req.pop),
    .raddr (pop_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      drain     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == spq_pkg::CMD_INSERT) begin
              res_status <= stat.full ? spq_pkg::ST_DROPPED : spq_pkg::ST_ACCEPTED;
              res_has    <= 1'b0;
              res_last   <= 1'b1;
              drain      <= 1'b0;
              state      <= S_EMIT;
            end else if (is_serve) begin
              if (stat.empty) begin
                res_status <= spq_pkg::ST_EMPTY;
                res_has    <= 1'b0;
                res_last   <= 1'b1;
                drain      <= 1'b0;
              end else begin
                res_status <= spq_pkg::ST_SERVED;
                res_has    <= 1'b1;
                res_level  <= stat.top_level;
                res_last   <= (cmd == spq_pkg::CMD_SERVE_ONE) || stat.last_one;
                drain      <= (cmd == spq_pkg::CMD_SERVE_ALL);
              end
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            status          <= res_status;
            last            <= res_last;
            served_tag      <= res_has ? rdata[DW-1:spq_pkg::CAT_W] : '0;
            served_level    <= res_has ? res_level : '0;
            served_category <= res_has ? rdata[spq_pkg::CAT_W-1:0] : '0;
            if (drain_more) begin
              // next entry was read at this edge
              res_level <= stat.top_level;
              res_last  <= stat.last_one;
            end else begin
              drain <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/spq_check.sv @@
// Port-level checks for the stable priority queue, bound to the top level.
module spq_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [spq_pkg::CMD_W-1:0]     cmd,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [spq_pkg::STATUS_W-1:0]  status,
  input logic [spq_pkg::TAG_W-1:0]     served_tag,
  input logic [spq_pkg::LEVEL_W-1:0]   served_level,
  input logic [spq_pkg::CAT_W-1:0]     served_category,
  input logic                          last
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(served_tag)
      && $stable(served_level) && $stable(served_category) && $stable(last))
    else $error("stalled result word changed");

  // An accepted command blocks the input until its results are formed.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && ((cmd == spq_pkg::CMD_INSERT)
      || (cmd == spq_pkg::CMD_SERVE_ONE) || (cmd == spq_pkg::CMD_SERVE_ALL))
      |=> in_stall)
    else $error("input taken back to back");

  // Anything but a served entry is a single, final word.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != spq_pkg::ST_SERVED) |-> last)
    else $error("non-serve result without last");

  // Non-serve results carry zero payload.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != spq_pkg::ST_SERVED) |->
      (served_tag == '0) && (served_level == '0) && (served_category == '0))
    else $error("non-serve result with payload");

endmodule

bind stable_priority_queue spq_check u_spq_check (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .cmd             (cmd),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .served_tag      (served_tag),
  .served_level    (served_level),
  .served_category (served_category),
  .last            (last)
);
